[hw/rtl/pwv_pkg.sv]
// shared types and constants for the pixel wave vertex generator
// no dependencies; used by pwv_csr_regs, pwv_divider and the core top level
package pwv_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int VERT_CAP     = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
   localparam int CNT_W        = $clog2(VERT_CAP + 1);

   // divider retires two quotient bits per cycle, 24 bits in all
   localparam int DIV_STEPS    = 12;

   localparam logic [20:0] ONE_QUARTER = 21'd65536;
   localparam logic [19:0] LEAD_MAX    = 20'hFFFFF;
   localparam logic [23:0] ONE_PIXEL   = 24'd256;

   localparam logic signed [26:0] Y_MAX = 27'sd8388607;
   localparam logic signed [26:0] Y_MIN = -27'sd8388608;

   // register indexes on the csr write channel
   localparam logic [2:0] CSR_LINE_LENGTH    = 3'd0;
   localparam logic [2:0] CSR_X_STEP         = 3'd1;
   localparam logic [2:0] CSR_ROW_PITCH      = 3'd2;
   localparam logic [2:0] CSR_AMP_GAIN       = 3'd3;
   localparam logic [2:0] CSR_PHASE_GAIN     = 3'd4;
   localparam logic [2:0] CSR_MIN_PHASE_STEP = 3'd5;
   localparam logic [2:0] CSR_MAX_PHASE_STEP = 3'd6;

   typedef struct packed {
      logic [13:0] line_length;
      logic [15:0] x_step;
      logic [23:0] row_pitch;
      logic [23:0] amp_gain;
      logic [15:0] phase_gain;
      logic [19:0] min_phase_step;
      logic [19:0] max_phase_step;
   } pwv_cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_LEAD,
      ST_DECIDE,
      ST_DIV_X,
      ST_DIV_A,
      ST_EMIT
   } pwv_state_type;

endpackage

[hw/rtl/pwv_csr_regs.sv]
// configuration register file written over the csr channel
// depends on pwv_pkg for the register indexes and the config struct
module pwv_csr_regs (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [23:0]          csr_data,
   output pwv_pkg::pwv_cfg_type cfg
);

   pwv_pkg::pwv_cfg_type cfg_ff;
   pwv_pkg::pwv_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            pwv_pkg::CSR_LINE_LENGTH:    cfg_in.line_length    = csr_data[13:0];
            pwv_pkg::CSR_X_STEP:         cfg_in.x_step         = csr_data[15:0];
            pwv_pkg::CSR_ROW_PITCH:      cfg_in.row_pitch      = csr_data;
            pwv_pkg::CSR_AMP_GAIN:       cfg_in.amp_gain       = csr_data;
            pwv_pkg::CSR_PHASE_GAIN:     cfg_in.phase_gain     = csr_data[15:0];
            pwv_pkg::CSR_MIN_PHASE_STEP: cfg_in.min_phase_step = csr_data[19:0];
            pwv_pkg::CSR_MAX_PHASE_STEP: cfg_in.max_phase_step = csr_data[19:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_length    <= 14'd256;
         cfg_ff.x_step         <= 16'd256;
         cfg_ff.row_pitch      <= 24'd2560;
         cfg_ff.amp_gain       <= 24'd65536;
         cfg_ff.phase_gain     <= 16'd256;
         cfg_ff.min_phase_step <= 20'd4096;
         cfg_ff.max_phase_step <= 20'd983040;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hw/rtl/pwv_divider.sv]
// shared restoring divider: quotient = mag * 65536 / divisor, two bits a cycle
// depends on pwv_pkg; divisor is always above one quarter turn, so the quotient fits 24 bits
module pwv_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [23:0] mag,
   input  logic [20:0] divisor,
   output logic        done,
   output logic [23:0] quotient
);

   logic [20:0] rem_ff, rem_in;
   logic [23:0] quo_ff, quo_in;
   logic [20:0] div_ff, div_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   logic [20:0] rem_a, rem_b;
   logic        q_a, q_b;

   // one restoring step: shift in a dividend bit, subtract when it fits
   function automatic logic [21:0] div_step(input logic [20:0] rem, input logic bit_in,
                                            input logic [20:0] d);
      logic [21:0] t;
      logic [21:0] diff;
      t    = {rem, bit_in};
      diff = t - {1'b0, d};
      if (t >= {1'b0, d}) div_step = {1'b1, diff[20:0]};
      else                div_step = {1'b0, t[20:0]};
   endfunction

   always_comb begin
      {q_a, rem_a} = div_step(rem_ff, quo_ff[23], div_ff);
      {q_b, rem_b} = div_step(rem_a, quo_ff[22], div_ff);

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         // the top 16 dividend bits are below the divisor, so start there
         rem_in  = {5'd0, mag[23:8]};
         quo_in  = {mag[7:0], 16'd0};
         div_in  = divisor;
         cnt_in  = 4'(pwv_pkg::DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = rem_b;
         quo_in = {quo_ff[21:0], q_a, q_b};
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hw/rtl/pixel_wave_vertex_generator_core.sv]
// top level of the pixel wave vertex generator
// depends on pwv_pkg, pwv_csr_regs and pwv_divider

// Each request word is one pixel sampled at the next position along the current trace
// row; the core answers with the quarter-turn vertices of an intensity-modulated sine
// trace (zero to sixteen words per pixel, the final one flagged on rsp_tlast). One pixel
// is handled at a time: multiply, then clamp, then compare, then, when vertices are due,
// two passes through the shared two-bit-per-cycle divider for the x and amplitude
// steps, then one vertex per cycle while rsp_tready stays high. The last vertex sits in
// the output register while the next pixel is already being accepted. Registers are to
// be written on the csr channel only while the core is idle; the user is bound to this,
// as the core itself does not enforce it.
module pixel_wave_vertex_generator_core (
   input  logic        clock,
   input  logic        reset,

   // pixel stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel
   input  logic        req_tuser,   // [0] frame_start

   // vertex stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [23:0] vertex_x, [47:24] vertex_y
   output logic        rsp_tuser,   // [0] reversed_row
   output logic        rsp_tlast,   // last_vertex

   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   localparam int CW = pwv_pkg::CNT_W;

   pwv_pkg::pwv_cfg_type   cfg;
   pwv_pkg::pwv_state_type state_ff, state_in;

   // trace state
   logic [23:0] sample_pos_ff, sample_pos_in;
   logic [23:0] prev_x_ff, prev_x_in;
   logic [19:0] phase_lead_ff, phase_lead_in;
   logic [1:0]  quadrant_ff, quadrant_in;
   logic [23:0] prev_amp_ff, prev_amp_in;
   logic [23:0] row_offset_ff, row_offset_in;
   logic        row_rev_ff, row_rev_in;

   // per-pixel working registers
   logic [7:0]    pixel_ff, pixel_in;
   logic [23:0]   amp_ff, amp_in;
   logic [23:0]   inc_ff, inc_in;
   logic          final_ff, final_in;
   logic [20:0]   lead_ff, lead_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] vidx_ff, vidx_in;
   logic [23:0]   dx_ff, dx_in;
   logic [23:0]   da_ff, da_in;
   logic          neg_ff, neg_in;
   logic [24:0]   base_ff, base_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_x_ff, rsp_x_in;
   logic [23:0] rsp_y_ff, rsp_y_in;
   logic        rsp_rev_ff, rsp_rev_in;
   logic        rsp_last_ff, rsp_last_in;

   // divider hookup
   logic        div_start;
   logic [23:0] div_mag;
   logic        div_done;
   logic [23:0] div_q;

   // combinational helpers
   logic [31:0]        amp_prod;
   logic [23:0]        inc_prod;
   logic [24:0]        next_pos;
   logic [23:0]        inc_lo;
   logic [19:0]        inc_c;
   logic [4:0]         lead_whole;
   logic [24:0]        diff;
   logic [20:0]        lead_rest;
   logic [23:0]        px_n, pa_n;
   logic [1:0]         q_n;
   logic signed [26:0] y_full;
   logic               fire;

   pwv_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pwv_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .mag      (div_mag),
      .divisor  (lead_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == pwv_pkg::ST_IDLE);
   assign fire       = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      sample_pos_in = sample_pos_ff;
      prev_x_in     = prev_x_ff;
      phase_lead_in = phase_lead_ff;
      quadrant_in   = quadrant_ff;
      prev_amp_in   = prev_amp_ff;
      row_offset_in = row_offset_ff;
      row_rev_in    = row_rev_ff;
      pixel_in      = pixel_ff;
      amp_in        = amp_ff;
      inc_in        = inc_ff;
      final_in      = final_ff;
      lead_in       = lead_ff;
      count_in      = count_ff;
      vidx_in       = vidx_ff;
      dx_in         = dx_ff;
      da_in         = da_ff;
      neg_in        = neg_ff;
      base_in       = base_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_rev_in    = rsp_rev_ff;
      rsp_last_in   = rsp_last_ff;
      div_start     = 1'b0;
      div_mag       = 24'd0;

      amp_prod   = pixel_ff * cfg.amp_gain;
      inc_prod   = pixel_ff * cfg.phase_gain;
      next_pos   = {1'b0, sample_pos_ff} + {9'd0, cfg.x_step};
      inc_lo     = (inc_ff < {4'd0, cfg.min_phase_step}) ? {4'd0, cfg.min_phase_step} : inc_ff;
      inc_c      = (inc_lo > {4'd0, cfg.max_phase_step}) ? cfg.max_phase_step : inc_lo[19:0];
      lead_whole = lead_ff[20:16];
      diff       = 25'd0;
      lead_rest  = lead_ff - 21'({count_ff, 16'd0});
      px_n       = prev_x_ff + dx_ff;
      pa_n       = prev_amp_ff + da_ff;
      q_n        = quadrant_ff + 2'd1;
      y_full     = $signed({2'b00, base_ff});
      if (q_n == 2'd1)      y_full = $signed({2'b00, base_ff}) + $signed({3'b000, pa_n});
      else if (q_n == 2'd3) y_full = $signed({2'b00, base_ff}) - $signed({3'b000, pa_n});

      case (state_ff)
         pwv_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               pixel_in      = req_tdata;
               sample_pos_in = next_pos[23:0];
               if (req_tuser) begin
                  row_offset_in = 24'd0;
                  row_rev_in    = 1'b0;
               end
               state_in = pwv_pkg::ST_MUL;
            end
         end
         pwv_pkg::ST_MUL: begin
            amp_in   = amp_prod[31:8];
            inc_in   = inc_prod;
            // row ends when the following sample would reach the line end
            final_in = next_pos >= {3'd0, cfg.line_length, 8'd0};
            state_in = pwv_pkg::ST_LEAD;
         end
         pwv_pkg::ST_LEAD: begin
            lead_in  = {1'b0, phase_lead_ff} + {1'b0, inc_c};
            base_in  = {1'b0, row_offset_ff} + {2'b00, cfg.row_pitch[23:1]};
            state_in = pwv_pkg::ST_DECIDE;
         end
         pwv_pkg::ST_DECIDE: begin
            if (final_ff) begin
               sample_pos_in = pwv_pkg::ONE_PIXEL;
               prev_x_in     = pwv_pkg::ONE_PIXEL;
               phase_lead_in = 20'd0;
               quadrant_in   = 2'd0;
               prev_amp_in   = 24'd0;
               row_offset_in = row_offset_ff + cfg.row_pitch;
               row_rev_in    = !row_rev_ff;
               state_in      = pwv_pkg::ST_IDLE;
            end else if (lead_ff <= pwv_pkg::ONE_QUARTER) begin
               phase_lead_in = lead_ff[19:0];
               state_in      = pwv_pkg::ST_IDLE;
            end else begin
               count_in  = (lead_whole > 5'(pwv_pkg::VERT_CAP)) ? CW'(pwv_pkg::VERT_CAP)
                                                                : CW'(lead_whole);
               vidx_in   = '0;
               diff      = {1'b0, sample_pos_ff} - {1'b0, prev_x_ff};
               neg_in    = diff[24];
               div_mag   = diff[24] ? 24'(-diff) : diff[23:0];
               div_start = 1'b1;
               state_in  = pwv_pkg::ST_DIV_X;
            end
         end
         pwv_pkg::ST_DIV_X: begin
            if (div_done) begin
               dx_in     = neg_ff ? -div_q : div_q;
               diff      = {1'b0, amp_ff} - {1'b0, prev_amp_ff};
               neg_in    = diff[24];
               div_mag   = diff[24] ? 24'(-diff) : diff[23:0];
               div_start = 1'b1;
               state_in  = pwv_pkg::ST_DIV_A;
            end
         end
         pwv_pkg::ST_DIV_A: begin
            if (div_done) begin
               da_in    = neg_ff ? -div_q : div_q;
               state_in = pwv_pkg::ST_EMIT;
            end
         end
         pwv_pkg::ST_EMIT: begin
            if (fire) begin
               prev_x_in    = px_n;
               prev_amp_in  = pa_n;
               quadrant_in  = q_n;
               rsp_valid_in = 1'b1;
               rsp_x_in     = px_n;
               if (y_full > pwv_pkg::Y_MAX)      rsp_y_in = 24'h7FFFFF;
               else if (y_full < pwv_pkg::Y_MIN) rsp_y_in = 24'h800000;
               else                              rsp_y_in = y_full[23:0];
               rsp_rev_in   = row_rev_ff;
               rsp_last_in  = (CW'(vidx_ff + 1'b1) == count_ff);
               vidx_in      = CW'(vidx_ff + 1'b1);
               if (CW'(vidx_ff + 1'b1) == count_ff) begin
                  // unemitted quarters stay in the lead
                  phase_lead_in = (lead_rest > {1'b0, pwv_pkg::LEAD_MAX}) ? pwv_pkg::LEAD_MAX
                                                                          : lead_rest[19:0];
                  state_in      = pwv_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = pwv_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pwv_pkg::ST_IDLE;
         sample_pos_ff <= pwv_pkg::ONE_PIXEL;
         prev_x_ff     <= pwv_pkg::ONE_PIXEL;
         phase_lead_ff <= 20'd0;
         quadrant_ff   <= 2'd0;
         prev_amp_ff   <= 24'd0;
         row_offset_ff <= 24'd0;
         row_rev_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sample_pos_ff <= sample_pos_in;
         prev_x_ff     <= prev_x_in;
         phase_lead_ff <= phase_lead_in;
         quadrant_ff   <= quadrant_in;
         prev_amp_ff   <= prev_amp_in;
         row_offset_ff <= row_offset_in;
         row_rev_ff    <= row_rev_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff    <= pixel_in;
      amp_ff      <= amp_in;
      inc_ff      <= inc_in;
      final_ff    <= final_in;
      lead_ff     <= lead_in;
      count_ff    <= count_in;
      vidx_ff     <= vidx_in;
      dx_ff       <= dx_in;
      da_ff       <= da_in;
      neg_ff      <= neg_in;
      base_ff     <= base_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_rev_ff  <= rsp_rev_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_rev_ff;
   assign rsp_tlast  = rsp_last_ff;

   // one pixel at a time: a taken word closes the input until the pixel is done
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("pixel accepted while previous pixel in flight");

   // divider results only show up where the sequencer waits for them
   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == pwv_pkg::ST_DIV_X || state_ff == pwv_pkg::ST_DIV_A))
      else $error("divider finished outside a divide state");

   // vertex counter never runs past the count fixed for this pixel
   a_emit_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == pwv_pkg::ST_EMIT |-> (count_ff != '0 && vidx_ff < count_ff))
      else $error("vertex index out of range");

endmodule
